// ===== design/twdc_pkg.sv =====
`default_nettype none
package twdc_pkg;

    localparam int NUM_SETS   = 64;
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int DATA_AW    = SET_W + 4;
    localparam int DATA_DEPTH = 16 * NUM_SETS;

    localparam int DIRTY_BIT = 6;
    localparam int VALID_BIT = 5;
    localparam int LRF_BIT   = 4;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_OP    = 2'd2;
    localparam logic [1:0] KIND_FILL  = 2'd3;

    localparam logic [1:0] RES_LOAD  = 2'd0;
    localparam logic [1:0] RES_WB    = 2'd1;
    localparam logic [1:0] RES_FILL  = 2'd2;
    localparam logic [1:0] RES_TAGLO = 2'd3;

    localparam logic [4:0] OP_HIT_INV    = 5'h1a;
    localparam logic [4:0] OP_HIT_WB_INV = 5'h18;
    localparam logic [4:0] OP_HIT_WB     = 5'h1c;
    localparam logic [4:0] OP_IDX_INV    = 5'h16;
    localparam logic [4:0] OP_IDX_WB_INV = 5'h14;
    localparam logic [4:0] OP_LD_DATA    = 5'h11;
    localparam logic [4:0] OP_LD_TAG     = 5'h10;
    localparam logic [4:0] OP_ST_DATA    = 5'h13;
    localparam logic [4:0] OP_ST_TAG     = 5'h12;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [2:0]  size_code;
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic [4:0]  cache_op;
        logic [31:0] tag_lo_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] result_address;
        logic [63:0] result_data;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB_RD,
        ST_WB_EMIT,
        ST_WB_DONE,
        ST_MISS_FIN,
        ST_CLR,
        ST_TAGLO,
        ST_ACC_RD,
        ST_ACC_EX,
        ST_ACC_WR2,
        ST_OP_EX
    } state_t;

    typedef enum logic [1:0] {
        CONT_NONE,
        CONT_MISS,
        CONT_CLEAR,
        CONT_TAGLO
    } cont_t;

    function automatic state_t cont_state(cont_t c);
        state_t s;
        case (c)
            CONT_MISS:  s = ST_MISS_FIN;
            CONT_CLEAR: s = ST_CLR;
            CONT_TAGLO: s = ST_TAGLO;
            default:    s = ST_IDLE;
        endcase
        return s;
    endfunction

    function automatic logic op_known(logic [4:0] op);
        return (op == OP_HIT_INV) || (op == OP_HIT_WB_INV) || (op == OP_HIT_WB) ||
               (op == OP_IDX_INV) || (op == OP_IDX_WB_INV) || (op == OP_LD_DATA) ||
               (op == OP_LD_TAG) || (op == OP_ST_DATA) || (op == OP_ST_TAG);
    endfunction

    function automatic logic [63:0] size_mask(logic [2:0] sc);
        logic [63:0] m;
        case (sc)
            3'd0:    m = 64'h0000_0000_0000_00FF;
            3'd1:    m = 64'h0000_0000_0000_FFFF;
            3'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    // bit shift of the aligned byte offset inside the word
    function automatic logic [5:0] byte_shift(logic [2:0] a, logic [2:0] sc);
        logic [2:0] off;
        case (sc)
            3'd0:    off = a;
            3'd1:    off = {a[2:1], 1'b0};
            3'd2:    off = {a[2], 2'b00};
            default: off = 3'd0;
        endcase
        return {off, 3'b000};
    endfunction

    function automatic logic [63:0] load_extract(logic [63:0] w, logic [2:0] a, logic [2:0] sc);
        return (w >> byte_shift(a, sc)) & size_mask(sc);
    endfunction

    function automatic logic [63:0] store_merge(logic [63:0] w, logic [63:0] d,
                                                logic [2:0] a, logic [2:0] sc);
        logic [63:0] m;
        logic [5:0]  sh;
        m  = size_mask(sc);
        sh = byte_shift(a, sc);
        return (w & ~(m << sh)) | ((d & m) << sh);
    endfunction

    function automatic logic [31:0] get_half(logic [63:0] pair, logic way);
        return way ? pair[63:32] : pair[31:0];
    endfunction

    function automatic logic [63:0] put_half(logic [63:0] pair, logic way, logic [31:0] t);
        return way ? {t, pair[31:0]} : {pair[63:32], t};
    endfunction

endpackage
`default_nettype wire

// ===== design/twdc_req_if.sv =====
`default_nettype none
interface twdc_req_if;
    import twdc_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/twdc_rsp_if.sv =====
`default_nettype none
interface twdc_rsp_if;
    import twdc_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/twdc_ram.sv =====
`default_nettype none
module twdc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/twdc_ctrl.sv =====
`default_nettype none
module twdc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    twdc_req_if.sink                      req,
    twdc_rsp_if.source                    rsp,
    output logic                          tag_we,
    output logic [twdc_pkg::SET_W-1:0]    tag_waddr,
    output logic [63:0]                   tag_wdata,
    output logic [twdc_pkg::SET_W-1:0]    tag_raddr,
    input  logic [63:0]                   tag_rdata,
    output logic                          data_we,
    output logic [twdc_pkg::DATA_AW-1:0]  data_waddr,
    output logic [63:0]                   data_wdata,
    output logic [twdc_pkg::DATA_AW-1:0]  data_raddr,
    input  logic [63:0]                   data_rdata
);
    import twdc_pkg::*;

    state_t             state_reg, state_next;
    cont_t              cont_reg, cont_next;
    req_t               cur_reg, cur_next;
    logic [63:0]        tags_reg, tags_next;
    logic               way_reg, way_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [DATA_AW-1:0] sweep_reg, sweep_next;
    logic [31:0]        pend_addr_reg, pend_addr_next;
    logic [2:0]         pend_sc_reg, pend_sc_next;
    logic               pend_st_reg, pend_st_next;
    logic               pend_way_reg, pend_way_next;
    logic [63:0]        pend_lo_reg, pend_lo_next;
    logic [63:0]        pend_hi_reg, pend_hi_next;
    logic [2:0]         fill_cnt_reg, fill_cnt_next;
    logic               waiting_reg, waiting_next;
    logic               wb_last_reg, wb_last_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic               accept, out_free;
    logic [SET_W-1:0]   cur_set, pend_set;
    logic [31:0]        t0, t1, look_t, way_t;
    logic               hit0, hit1, hit, hit_way, victim, is_mem;
    logic               look_way, look_wb, look_dirty;
    cont_t              look_cont;
    state_t             look_alt, look_next;
    logic               pend_st16;
    logic [2:0]         acc_word;
    logic [31:0]        wb_line;

    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cur_set   = cur_reg.address[6 +: SET_W];
    assign pend_set  = pend_addr_reg[6 +: SET_W];
    assign pend_st16 = pend_st_reg && pend_sc_reg[2];
    assign acc_word  = pend_st16 ? {pend_addr_reg[5:4], 1'b0} : pend_addr_reg[5:3];
    assign way_t     = get_half(tags_reg, way_reg);
    assign wb_line   = {way_t[31:12], 12'b0} | {{(26 - SET_W){1'b0}}, cur_set, 6'b0};

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // tag compare on the pair read for the current transaction
    always_comb
    begin
        t0      = tag_rdata[31:0];
        t1      = tag_rdata[63:32];
        hit0    = t0[VALID_BIT] && (t0[31:12] == cur_reg.address[31:12]);
        hit1    = t1[VALID_BIT] && (t1[31:12] == cur_reg.address[31:12]);
        hit     = hit0 || hit1;
        hit_way = !hit0;
        victim  = t0[LRF_BIT] ^ t1[LRF_BIT];
        is_mem  = (cur_reg.kind == KIND_LOAD) || (cur_reg.kind == KIND_STORE);

        look_way  = cur_reg.address[0];
        look_cont = CONT_NONE;
        look_wb   = 1'b0;
        look_alt  = ST_IDLE;
        if (is_mem)
        begin
            if (hit)
            begin
                look_way = hit_way;
                look_alt = ST_ACC_RD;
            end
            else
            begin
                look_way  = victim;
                look_cont = CONT_MISS;
                look_wb   = 1'b1;
            end
        end
        else
        begin
            case (cur_reg.cache_op)
                OP_HIT_INV:
                begin
                    look_way = hit_way;
                    look_alt = hit ? ST_CLR : ST_IDLE;
                end
                OP_HIT_WB_INV:
                begin
                    look_way  = hit_way;
                    look_cont = CONT_CLEAR;
                    look_wb   = hit;
                end
                OP_HIT_WB:
                begin
                    look_way = hit_way;
                    look_wb  = hit;
                end
                OP_IDX_INV:
                begin
                    look_alt = ST_CLR;
                end
                OP_IDX_WB_INV:
                begin
                    look_cont = CONT_CLEAR;
                    look_wb   = 1'b1;
                end
                OP_LD_DATA, OP_ST_DATA:
                begin
                    look_alt = ST_OP_EX;
                end
                OP_LD_TAG:
                begin
                    look_cont = CONT_TAGLO;
                    look_wb   = 1'b1;
                end
                default:
                begin
                    look_alt = ST_IDLE;
                end
            endcase
        end
        look_t     = look_way ? t1 : t0;
        look_dirty = look_t[DIRTY_BIT] && look_t[VALID_BIT];
        if (look_wb)
        begin
            look_next = look_dirty ? ST_WB_RD : cont_state(look_cont);
        end
        else
        begin
            look_next = look_alt;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (&sweep_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.payload.kind == KIND_FILL)
                    begin
                        if (waiting_reg && (fill_cnt_reg == 3'd7))
                        begin
                            state_next = ST_ACC_RD;
                        end
                    end
                    else if (!waiting_reg &&
                             ((req.payload.kind != KIND_OP) || op_known(req.payload.cache_op)))
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:   state_next = look_next;
            ST_WB_RD:    state_next = ST_WB_EMIT;
            ST_WB_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (cnt_reg == 3'd7) ? ST_WB_DONE : ST_WB_RD;
                end
            end
            ST_WB_DONE:  state_next = cont_state(cont_reg);
            ST_MISS_FIN, ST_TAGLO:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (cnt_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC_RD:   state_next = ST_ACC_EX;
            ST_ACC_EX:
            begin
                if (pend_st16)
                begin
                    state_next = ST_ACC_WR2;
                end
                else if (pend_st_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC_WR2:  state_next = ST_IDLE;
            ST_OP_EX:
            begin
                if ((cur_reg.cache_op != OP_LD_DATA) || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath, memory ports and results
    always_comb
    begin
        cont_next      = cont_reg;
        cur_next       = cur_reg;
        tags_next      = tags_reg;
        way_next       = way_reg;
        cnt_next       = cnt_reg;
        sweep_next     = sweep_reg;
        pend_addr_next = pend_addr_reg;
        pend_sc_next   = pend_sc_reg;
        pend_st_next   = pend_st_reg;
        pend_way_next  = pend_way_reg;
        pend_lo_next   = pend_lo_reg;
        pend_hi_next   = pend_hi_reg;
        fill_cnt_next  = fill_cnt_reg;
        waiting_next   = waiting_reg;
        wb_last_next   = wb_last_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;

        tag_raddr  = req.payload.address[6 +: SET_W];
        tag_we     = 1'b0;
        tag_waddr  = cur_set;
        tag_wdata  = tags_reg;
        data_we    = 1'b0;
        data_waddr = {cur_set, way_reg, cnt_reg};
        data_wdata = '0;
        data_raddr = {pend_set, pend_way_reg, acc_word};

        case (state_reg)
            ST_SWEEP:
            begin
                tag_we     = 1'b1;
                tag_waddr  = sweep_reg[DATA_AW-1:4];
                tag_wdata  = '0;
                data_we    = 1'b1;
                data_waddr = sweep_reg;
                data_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_next = req.payload;
                    if ((req.payload.kind == KIND_FILL) && waiting_reg)
                    begin
                        data_we       = 1'b1;
                        data_waddr    = {pend_set, pend_way_reg, fill_cnt_reg};
                        data_wdata    = req.payload.data_low;
                        fill_cnt_next = fill_cnt_reg + 1'b1;
                        if (fill_cnt_reg == 3'd7)
                        begin
                            waiting_next = 1'b0;
                        end
                    end
                end
            end
            ST_LOOKUP:
            begin
                tags_next    = tag_rdata;
                way_next     = look_way;
                cont_next    = look_cont;
                cnt_next     = 3'd0;
                wb_last_next = (look_cont == CONT_NONE) || (look_cont == CONT_CLEAR);
                data_raddr   = {cur_set, cur_reg.address[0], cur_reg.address[5:3]};
                if (is_mem)
                begin
                    pend_addr_next = cur_reg.address;
                    pend_sc_next   = cur_reg.size_code;
                    pend_st_next   = (cur_reg.kind == KIND_STORE);
                    pend_way_next  = look_way;
                    pend_lo_next   = cur_reg.data_low;
                    pend_hi_next   = cur_reg.data_high;
                end
                else if (cur_reg.cache_op == OP_ST_TAG)
                begin
                    tag_we    = 1'b1;
                    tag_wdata = put_half(tag_rdata, cur_reg.address[0],
                                         {look_t[31:12], cur_reg.tag_lo_in[11:0]});
                    tags_next = tag_wdata;
                end
            end
            ST_WB_RD:
            begin
                data_raddr = {cur_set, way_reg, cnt_reg};
            end
            ST_WB_EMIT:
            begin
                data_raddr = {cur_set, way_reg, cnt_reg};
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_next.result_kind       = RES_WB;
                    out_next.result_address    = wb_line;
                    out_next.result_data       = data_rdata;
                    out_next.last              = (cnt_reg == 3'd7) && wb_last_reg;
                    cnt_next                   = (cnt_reg == 3'd7) ? 3'd0 : cnt_reg + 1'b1;
                end
            end
            ST_WB_DONE:
            begin
                tag_we    = 1'b1;
                tag_wdata = put_half(tags_reg, way_reg,
                                     way_t & ~(32'd1 << DIRTY_BIT));
                tags_next = tag_wdata;
            end
            ST_MISS_FIN:
            begin
                if (out_free)
                begin
                    tag_we    = 1'b1;
                    tag_wdata = put_half(tags_reg, way_reg,
                                         {cur_reg.address[31:12], way_t[11:7], 1'b0, 1'b1,
                                          ~way_t[4], way_t[3:0]});
                    tags_next = tag_wdata;
                    out_valid_next          = 1'b1;
                    out_next.result_kind    = RES_FILL;
                    out_next.result_address = {cur_reg.address[31:6], 6'b0};
                    out_next.result_data    = '0;
                    out_next.last           = 1'b1;
                    fill_cnt_next           = 3'd0;
                    waiting_next            = 1'b1;
                end
            end
            ST_CLR:
            begin
                data_we    = 1'b1;
                data_waddr = {cur_set, way_reg, cnt_reg};
                data_wdata = '0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == 3'd7)
                begin
                    tag_we    = 1'b1;
                    tag_wdata = put_half(tags_reg, way_reg, way_t & (32'd1 << LRF_BIT));
                    tags_next = tag_wdata;
                end
            end
            ST_TAGLO:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.result_kind    = RES_TAGLO;
                    out_next.result_address = '0;
                    out_next.result_data    = {52'b0, way_t[11:0]};
                    out_next.last           = 1'b1;
                end
            end
            ST_ACC_EX:
            begin
                tag_waddr  = pend_set;
                data_waddr = {pend_set, pend_way_reg, acc_word};
                if (pend_st_reg)
                begin
                    data_we    = 1'b1;
                    data_wdata = pend_st16 ? pend_lo_reg :
                                 store_merge(data_rdata, pend_lo_reg,
                                             pend_addr_reg[2:0], pend_sc_reg);
                    tag_we     = 1'b1;
                    tag_wdata  = put_half(tags_reg, pend_way_reg,
                                          get_half(tags_reg, pend_way_reg) |
                                          (32'd1 << DIRTY_BIT));
                    tags_next  = tag_wdata;
                end
                else if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.result_kind    = RES_LOAD;
                    out_next.result_address = '0;
                    out_next.result_data    = load_extract(data_rdata, pend_addr_reg[2:0],
                                                           pend_sc_reg);
                    out_next.last           = 1'b1;
                end
            end
            ST_ACC_WR2:
            begin
                data_we    = 1'b1;
                data_waddr = {pend_set, pend_way_reg, acc_word | 3'd1};
                data_wdata = pend_hi_reg;
            end
            ST_OP_EX:
            begin
                data_raddr = {cur_set, cur_reg.address[0], cur_reg.address[5:3]};
                data_waddr = data_raddr;
                if (cur_reg.cache_op == OP_LD_DATA)
                begin
                    if (out_free)
                    begin
                        out_valid_next          = 1'b1;
                        out_next.result_kind    = RES_TAGLO;
                        out_next.result_address = '0;
                        out_next.result_data    = {32'b0, cur_reg.address[2] ?
                                                   data_rdata[63:32] : data_rdata[31:0]};
                        out_next.last           = 1'b1;
                    end
                end
                else
                begin
                    data_we    = 1'b1;
                    data_wdata = cur_reg.address[2] ?
                                 {cur_reg.tag_lo_in, data_rdata[31:0]} :
                                 {data_rdata[63:32], cur_reg.tag_lo_in};
                end
            end
            default:
            begin
                data_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            cont_reg      <= CONT_NONE;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            fill_cnt_reg  <= '0;
            waiting_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cont_reg      <= cont_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            fill_cnt_reg  <= fill_cnt_next;
            waiting_reg   <= waiting_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        tags_reg      <= tags_next;
        way_reg       <= way_next;
        pend_addr_reg <= pend_addr_next;
        pend_sc_reg   <= pend_sc_next;
        pend_st_reg   <= pend_st_next;
        pend_way_reg  <= pend_way_next;
        pend_lo_reg   <= pend_lo_next;
        pend_hi_reg   <= pend_hi_next;
        wb_last_reg   <= wb_last_next;
        out_reg       <= out_next;
    end
endmodule
`default_nettype wire

// ===== design/two_way_writeback_data_cache_top.sv =====
// hit: lookup, data read, access; loads wait for a free output, 16-byte stores write a second word
// one transaction at a time; tag and data memories are single read/single write, registered read
// miss or writeback: each writeback beat is a data memory read, then the output register once it is free
// fill beats are taken one per cycle; the eighth completes the pending access via data read and access
// after reset a clearing pass over all 16*NUM_SETS (1024) data words zeroes both memories, ready low
`default_nettype none
module two_way_writeback_data_cache_top (
    input logic        clk,
    input logic        rst_n,
    twdc_req_if.sink   req,
    twdc_rsp_if.source rsp
);
    import twdc_pkg::*;

    logic               tag_we;
    logic [SET_W-1:0]   tag_waddr, tag_raddr;
    logic [63:0]        tag_wdata, tag_rdata;
    logic               data_we;
    logic [DATA_AW-1:0] data_waddr, data_raddr;
    logic [63:0]        data_wdata, data_rdata;

    twdc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .tag_we     (tag_we),
        .tag_waddr  (tag_waddr),
        .tag_wdata  (tag_wdata),
        .tag_raddr  (tag_raddr),
        .tag_rdata  (tag_rdata),
        .data_we    (data_we),
        .data_waddr (data_waddr),
        .data_wdata (data_wdata),
        .data_raddr (data_raddr),
        .data_rdata (data_rdata)
    );

    // both ways of a set side by side
    twdc_ram #(.WIDTH(64), .DEPTH(NUM_SETS)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    twdc_ram #(.WIDTH(64), .DEPTH(DATA_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );
endmodule
`default_nettype wire

// ===== sim/tb_two_way_writeback_data_cache_top.sv =====
`default_nettype none
module tb_two_way_writeback_data_cache_top;
    import twdc_pkg::*;

    logic clk;
    logic rst_n;

    twdc_req_if req ();
    twdc_rsp_if rsp ();

    two_way_writeback_data_cache_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    int error_count = 0;

    task automatic report(input string what, input rsp_t got, input rsp_t want);
        $display("mismatch %s: got k=%0d a=%h d=%h l=%0d want k=%0d a=%h d=%h l=%0d",
                 what, got.result_kind, got.result_address, got.result_data, got.last,
                 want.result_kind, want.result_address, want.result_data, want.last);
        error_count++;
    endtask

    // behavioral copy of the cache used to predict results
    class cache_scoreboard;
        logic [31:0] tags [2*NUM_SETS];
        logic [63:0] words [16*NUM_SETS];
        logic [31:0] pend_addr;
        logic [2:0]  pend_size;
        logic        pend_store;
        logic        pend_way;
        logic [63:0] pend_lo;
        logic [63:0] pend_hi;
        int          fill_beats;
        logic        waiting;
        rsp_t        expected_q [$];
        rsp_t        step_q [$];

        function new();
            foreach (tags[i]) tags[i] = '0;
            foreach (words[i]) words[i] = '0;
            waiting = 0;
            fill_beats = 0;
        endfunction

        function void push(logic [1:0] k, logic [31:0] a, logic [63:0] d);
            rsp_t r;
            r.result_kind = k;
            r.result_address = a;
            r.result_data = d;
            r.last = 1'b0;
            step_q.push_back(r);
        endfunction

        function int set_of(logic [31:0] a);
            return (a >> 6) % NUM_SETS;
        endfunction

        function int base_of(int s, logic w);
            return (s * 2 + w) * 8;
        endfunction

        function bit find_way(int s, logic [31:0] a, output logic w);
            for (int i = 0; i < 2; i++) begin
                if (tags[s*2+i][VALID_BIT] && tags[s*2+i][31:12] == a[31:12]) begin
                    w = i[0];
                    return 1;
                end
            end
            w = 0;
            return 0;
        endfunction

        function void flush_line(int s, logic w);
            logic [31:0] line;
            if (!(tags[s*2+w][DIRTY_BIT] && tags[s*2+w][VALID_BIT]))
                return;
            line = {tags[s*2+w][31:12], 12'h0} | (s << 6);
            for (int i = 0; i < 8; i++)
                push(RES_WB, line, words[base_of(s, w) + i]);
            tags[s*2+w][DIRTY_BIT] = 1'b0;
        endfunction

        function void clear_line(int s, logic w);
            tags[s*2+w] = tags[s*2+w] & (32'h1 << LRF_BIT);
            for (int i = 0; i < 8; i++)
                words[base_of(s, w) + i] = '0;
        endfunction

        function void touch(bit st, logic [31:0] a, logic [2:0] sc, logic w,
                            logic [63:0] lo, logic [63:0] hi);
            int s, b, nb, off, sh;
            logic [63:0] m;
            s = set_of(a);
            b = base_of(s, w);
            if (st && sc >= 4) begin
                words[b + ((a >> 3) & 6)] = lo;
                words[b + ((a >> 3) & 6) + 1] = hi;
            end else begin
                nb = 1 << (sc > 3 ? 3 : sc);
                off = (a & 32'h3f) & ~(nb - 1);
                sh = (off & 7) * 8;
                m = (nb == 8) ? '1 : ((64'd1 << (nb * 8)) - 1);
                if (st)
                    words[b + off/8] = (words[b + off/8] & ~(m << sh)) | ((lo & m) << sh);
                else
                    push(RES_LOAD, 0, (words[b + off/8] >> sh) & m);
            end
            if (st)
                tags[s*2+w][DIRTY_BIT] = 1'b1;
        endfunction

        function void note_request(req_t q);
            int s, wi, sh;
            logic w, hw;
            step_q.delete();
            s = set_of(q.address);
            if (q.kind == KIND_FILL) begin
                if (!waiting)
                    return;
                words[base_of(set_of(pend_addr), pend_way) + fill_beats] = q.data_low;
                fill_beats++;
                if (fill_beats < 8)
                    return;
                fill_beats = 0;
                waiting = 0;
                touch(pend_store, pend_addr, pend_size, pend_way, pend_lo, pend_hi);
            end else if (waiting) begin
                return;
            end else if (q.kind == KIND_OP) begin
                w = q.address[0];
                wi = base_of(s, w) + ((q.address >> 3) & 7);
                sh = q.address[2] * 32;
                case (q.cache_op)
                    OP_HIT_INV: if (find_way(s, q.address, hw)) clear_line(s, hw);
                    OP_HIT_WB_INV:
                        if (find_way(s, q.address, hw))
                        begin
                            flush_line(s, hw);
                            clear_line(s, hw);
                        end
                    OP_HIT_WB: if (find_way(s, q.address, hw)) flush_line(s, hw);
                    OP_IDX_INV: clear_line(s, w);
                    OP_IDX_WB_INV:
                    begin
                        flush_line(s, w);
                        clear_line(s, w);
                    end
                    OP_LD_DATA: push(RES_TAGLO, 0, (words[wi] >> sh) & 64'hffff_ffff);
                    OP_LD_TAG:
                    begin
                        flush_line(s, w);
                        push(RES_TAGLO, 0, {52'h0, tags[s*2+w][11:0]});
                    end
                    OP_ST_DATA:
                        words[wi] = (words[wi] & ~(64'hffff_ffff << sh)) |
                                    ({32'h0, q.tag_lo_in} << sh);
                    OP_ST_TAG: tags[s*2+w][11:0] = q.tag_lo_in[11:0];
                    default: ;
                endcase
            end else begin
                if (find_way(s, q.address, hw)) begin
                    touch(q.kind == KIND_STORE, q.address, q.size_code, hw,
                          q.data_low, q.data_high);
                end else begin
                    w = tags[s*2][LRF_BIT] ^ tags[s*2+1][LRF_BIT];
                    flush_line(s, w);
                    tags[s*2+w] = {q.address[31:12], tags[s*2+w][11:0]};
                    tags[s*2+w][VALID_BIT] = 1'b1;
                    tags[s*2+w][DIRTY_BIT] = 1'b0;
                    tags[s*2+w][LRF_BIT] = ~tags[s*2+w][LRF_BIT];
                    push(RES_FILL, {q.address[31:6], 6'h0}, 64'd0);
                    pend_addr = q.address;
                    pend_size = q.size_code;
                    pend_store = (q.kind == KIND_STORE);
                    pend_way = w;
                    pend_lo = q.data_low;
                    pend_hi = q.data_high;
                    fill_beats = 0;
                    waiting = 1;
                end
            end
            if (step_q.size() > 0)
                step_q[step_q.size()-1].last = 1'b1;
            foreach (step_q[i]) expected_q.push_back(step_q[i]);
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0) begin
                report("unexpected", got, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_kind !== want.result_kind) report("kind", got, want);
            else if (got.result_address !== want.result_address) report("address", got, want);
            else if (got.result_data !== want.result_data) report("data", got, want);
            else if (got.last !== want.last) report("last", got, want);
        endtask
    endclass

    cache_scoreboard sb;
    req_t stim_q [$];
    bit   hold_off = 0;

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("two_way_writeback_data_cache_top regression: fail");
        $finish;
    end

    // address pool drawn from few tags so that hits, misses and evictions all happen
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(0, 9) < 8) begin
            a[31:12] = {18'h0, 2'($urandom_range(0, 3))};
            a[11:6] = 6'($urandom_range(0, 3));
        end
        return a;
    endfunction

    function automatic req_t make_req(logic [1:0] k, logic [31:0] a, logic [2:0] sc,
                                      logic [4:0] op);
        req_t q;
        q.kind = k;
        q.address = a;
        q.size_code = sc;
        q.data_low = {$urandom, $urandom};
        q.data_high = {$urandom, $urandom};
        q.cache_op = op;
        q.tag_lo_in = $urandom;
        return q;
    endfunction

    task automatic add_fills();
        for (int i = 0; i < 8; i++)
            stim_q.push_back(make_req(KIND_FILL, 32'($urandom), 3'd0, 5'd0));
    endtask

    task automatic add_access(logic [1:0] k, logic [31:0] a, logic [2:0] sc);
        stim_q.push_back(make_req(k, a, sc, 5'd0));
        add_fills();
    endtask

    task automatic build_stimulus();
        logic [4:0] ops [9];
        req_t q;
        int r;
        ops = '{OP_HIT_INV, OP_HIT_WB_INV, OP_HIT_WB, OP_IDX_INV, OP_IDX_WB_INV,
                OP_LD_DATA, OP_LD_TAG, OP_ST_DATA, OP_ST_TAG};
        // directed: miss, all sizes, extremes, eviction of dirty line, ops
        add_access(KIND_STORE, 32'h0000_0000, 3'd4);
        stim_q.push_back(make_req(KIND_LOAD, 32'h0000_0007, 3'd0, 5'd0));
        stim_q.push_back(make_req(KIND_LOAD, 32'h0000_000f, 3'd1, 5'd0));
        stim_q.push_back(make_req(KIND_LOAD, 32'h0000_003f, 3'd7, 5'd0));
        stim_q.push_back(make_req(KIND_STORE, 32'h0000_0035, 3'd2, 5'd0));
        stim_q.push_back(make_req(KIND_STORE, 32'h0000_0019, 3'd6, 5'd0));
        add_access(KIND_LOAD, 32'hffff_f000, 3'd3);
        add_access(KIND_STORE, 32'h0000_1000, 3'd0);
        stim_q.push_back(make_req(KIND_FILL, 32'd0, 3'd0, 5'd0));
        stim_q.push_back(make_req(KIND_OP, 32'h0000_1000, 3'd0, 5'h1f));
        foreach (ops[i]) stim_q.push_back(make_req(KIND_OP, pick_addr(), 3'd0, ops[i]));
        // random: well-formed sequences mostly, some stray fills and ignored items
        while (stim_q.size() < 470) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                q = make_req(2'($urandom_range(0, 1)), pick_addr(),
                             3'($urandom_range(0, 7)), 5'd0);
                stim_q.push_back(q);
                add_fills();
                if ($urandom_range(0, 3) == 0)
                    stim_q.push_back(make_req(2'($urandom_range(0, 2)), pick_addr(),
                                              3'($urandom_range(0, 7)), 5'($urandom)));
            end else if (r < 90) begin
                stim_q.push_back(make_req(KIND_OP, pick_addr(), 3'($urandom),
                                          ($urandom_range(0, 7) == 0) ? 5'($urandom)
                                                                      : ops[$urandom_range(0, 8)]));
            end else begin
                stim_q.push_back(make_req(2'($urandom_range(0, 3)), 32'($urandom),
                                          3'($urandom), 5'($urandom)));
            end
        end
    endtask

    task automatic drive_requests();
        int burst;
        int gap;
        req_t q;
        while (stim_q.size() > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && stim_q.size() > 0) begin
                q = stim_q.pop_front();
                req.valid <= 1'b1;
                req.payload <= q;
                // ready only moves at the rising edge, so the falling edge shows its value
                @(negedge clk);
                while (!req.ready) @(negedge clk);
                @(posedge clk);
                sb.note_request(q);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req.valid <= 1'b0;
    endtask

    // receiver: random stalls, plain stretches, and one long hold-off
    initial begin
        int cyc;
        bit fire;
        rsp_t got;
        rsp.ready = 1'b0;
        cyc = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            fire = rsp.valid && rsp.ready;
            got = rsp.payload;
            @(posedge clk);
            cyc++;
            if (fire) sb.check_result(got);
            if (cyc >= 1200 && cyc < 1700) hold_off = 1;
            else hold_off = 0;
            if (hold_off) rsp.ready <= 1'b0;
            else if ((cyc / 200) % 3 == 0) rsp.ready <= 1'b1;
            else rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        int wait_cycles;
        sb = new();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.payload = '0;
        build_stimulus();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        drive_requests();
        wait_cycles = 0;
        while (sb.expected_q.size() > 0 && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (error_count == 0 && sb.expected_q.size() == 0)
            $display("two_way_writeback_data_cache_top regression: pass");
        else
            $display("two_way_writeback_data_cache_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
